// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/mpdm_pkg.sv =====
// ----------------------------------------------------------------------------
// mpdm_pkg
// Types, codes and character mapping for the multi-pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none
package mpdm_pkg;

  localparam int NUM_STATES = 1024;
  localparam int ALPHABET   = 256;
  localparam int MAX_PAT    = 1024;
  localparam int MAX_OUT    = 16;
  localparam int MAX_LEN    = 1024;
  localparam int POS_BITS   = 40;

  localparam logic [2:0] FN_SCAN = 3'd0;
  localparam logic [2:0] FN_GOTO = 3'd1;
  localparam logic [2:0] FN_FAIL = 3'd2;
  localparam logic [2:0] FN_OENT = 3'd3;
  localparam logic [2:0] FN_OCNT = 3'd4;
  localparam logic [2:0] FN_PLEN = 3'd5;

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_N = 8'h4E;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_GO, ST_GCHK, ST_FCHK, ST_CNT, ST_LST, ST_LEN
  } acm_state_t;

  typedef struct packed {
    logic go;
    logic fail;
    logic cnt;
    logic lst;
    logic len;
  } mem_we_t;

  // strand complement (case-insensitive), then optional lowercase
  function automatic logic [7:0] map_char(input logic [7:0] ch, input logic rev,
                                          input logic ic);
    logic [7:0] u;
    logic [7:0] c;
    u = ch;
    c = ch;
    if (rev) begin
      if (ch inside {[8'h61:8'h7A]}) u = ch - 8'd32;
      case (u)
        CH_A: c = CH_T;
        CH_T: c = CH_A;
        CH_G: c = CH_C;
        CH_C: c = CH_G;
        default: c = CH_N;
      endcase
    end
    if (ic && (c inside {[8'h41:8'h5A]})) c = c + 8'd32;
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/mpdm_mem.sv =====
// ----------------------------------------------------------------------------
// mpdm_mem
// Automaton tables: one write port and one registered read port each.
// ----------------------------------------------------------------------------
`default_nettype none
module mpdm_mem #(
  parameter int SW = 10,
  parameter int PW = 10,
  parameter int OW = 4,
  parameter int CW = 5,
  parameter int LW = 11
) (
  input  wire                 clk,
  input  mpdm_pkg::mem_we_t   we,
  input  wire [SW-1:0]        w_node,
  input  wire [7:0]           w_ch,
  input  wire [OW-1:0]        w_slot,
  input  wire [PW-1:0]        w_pidx,
  input  wire [SW-1:0]        w_next,
  input  wire [PW-1:0]        w_pat,
  input  wire [CW-1:0]        w_cnt,
  input  wire [LW-1:0]        w_len,
  input  wire [SW+7:0]        r_go,
  input  wire [SW-1:0]        r_fail,
  input  wire [SW-1:0]        r_cnt,
  input  wire [SW+OW-1:0]     r_lst,
  input  wire [PW-1:0]        r_len,
  output logic [SW-1:0]       go_data,
  output logic [SW-1:0]       fail_data,
  output logic [CW-1:0]       cnt_data,
  output logic [PW-1:0]       lst_data,
  output logic [LW-1:0]       len_data
);

  logic [SW-1:0] go_mem   [2**(SW+8)];
  logic [SW-1:0] fail_mem [2**SW];
  logic [CW-1:0] cnt_mem  [2**SW];
  logic [PW-1:0] lst_mem  [2**(SW+OW)];
  logic [LW-1:0] len_mem  [2**PW];

  always_ff @(posedge clk) begin
    if (we.go)   go_mem[{w_node, w_ch}]     <= w_next;
    if (we.fail) fail_mem[w_node]           <= w_next;
    if (we.cnt)  cnt_mem[w_node]            <= w_cnt;
    if (we.lst)  lst_mem[{w_node, w_slot}]  <= w_pat;
    if (we.len)  len_mem[w_pidx]            <= w_len;
    go_data   <= go_mem[r_go];
    fail_data <= fail_mem[r_fail];
    cnt_data  <= cnt_mem[r_cnt];
    lst_data  <= lst_mem[r_lst];
    len_data  <= len_mem[r_len];
  end

endmodule
`default_nettype wire

// ===== sv/multi_pattern_dna_matcher.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_dna_matcher
// Aho-Corasick scanner: table load items, scan items, match items.
// ----------------------------------------------------------------------------
// Sequence: a write item is taken while idle and leaves the block idle. A scan item
//   runs GO and GCHK, then FCHK and GO again per failure link followed, then CNT,
//   then LST and LEN per match item; a walk cut off at NUM_STATES links retries
//   from the root. A match item waits in LEN while the output stalls.
// Flow: one item at a time; in_stall is high outside IDLE. Reset: synchronous; then a
//   pass over every goto address clears the goto/failure/count tables with in_stall high.
`default_nettype none
module multi_pattern_dna_matcher #(
  parameter int NUM_STATES = mpdm_pkg::NUM_STATES,
  parameter int MAX_PAT    = mpdm_pkg::MAX_PAT,
  parameter int MAX_OUT    = mpdm_pkg::MAX_OUT,
  parameter int MAX_LEN    = mpdm_pkg::MAX_LEN,
  parameter int POS_BITS   = mpdm_pkg::POS_BITS
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_we,
  input  wire                 cfg_data,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire [2:0]           func,
  input  wire [7:0]           ch,
  input  wire                 restart,
  input  wire                 strand,
  input  wire [POS_BITS-1:0]  position,
  input  wire [9:0]           node,
  input  wire [3:0]           slot,
  input  wire [10:0]          value,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [9:0]          match_pattern,
  output logic [POS_BITS-1:0] match_position,
  output logic                match_strand,
  output logic                last
);

  localparam int SW  = $clog2(NUM_STATES);
  localparam int PW  = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;
  localparam int OW  = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int CW  = $clog2(MAX_OUT + 1);
  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int STW = $clog2(NUM_STATES + 1);
  localparam int GAW = SW + 8;

  mpdm_pkg::acm_state_t st, st_next;

  logic [SW-1:0]       s, s_next, cur, cur_next;
  logic [7:0]          c, c_next;
  logic [STW-1:0]      steps, steps_next;
  logic [CW-1:0]       n, n_next, j, j_next, j_rd;
  logic [PW-1:0]       p, p_next;
  logic [POS_BITS-1:0] pos_r, pos_next;
  logic                strand_r, strand_next;
  logic [GAW-1:0]      clr, clr_next;
  logic                ic;
  logic                emit;

  // memory side
  mpdm_pkg::mem_we_t   we;
  logic [SW-1:0]       w_node, w_next;
  logic [7:0]          w_ch;
  logic [OW-1:0]       w_slot;
  logic [PW-1:0]       w_pidx, w_pat;
  logic [CW-1:0]       w_cnt;
  logic [LW-1:0]       w_len;
  logic [SW+7:0]       r_go;
  logic [SW-1:0]       r_fail, r_cnt;
  logic [SW+OW-1:0]    r_lst;
  logic [PW-1:0]       r_len;
  logic [SW-1:0]       go_data, fail_data;
  logic [CW-1:0]       cnt_data;
  logic [PW-1:0]       lst_data;
  logic [LW-1:0]       len_data;

  // widened copies of write fields for range checks and part-selects
  logic [31:0] node_w, val_w, slot_w, cnt_sat, len_sat, pidx_w;
  logic [63:0] fwd_pos;
  logic        accept;

  assign node_w  = 32'(node);
  assign val_w   = 32'(value);
  assign slot_w  = 32'(slot);
  assign cnt_sat = (val_w > 32'(MAX_OUT)) ? 32'(MAX_OUT) : val_w;
  assign len_sat = (val_w > 32'(MAX_LEN)) ? 32'(MAX_LEN) : val_w;
  assign pidx_w  = 32'(p);
  assign fwd_pos = 64'(pos_r) - 64'(len_data) + 64'd1;

  assign in_stall = (st != mpdm_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign emit     = (st == mpdm_pkg::ST_LEN) && (!out_valid || !out_stall);

  // config register: the user must write it only while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      ic <= 1'b0;
    end else if (cfg_we) begin
      ic <= cfg_data;
    end
  end

  // write port: clearing pass or host write items
  always_comb begin
    we     = '0;
    w_node = node_w[SW-1:0];
    w_ch   = ch;
    w_slot = slot_w[OW-1:0];
    w_pidx = node_w[PW-1:0];
    w_next = val_w[SW-1:0];
    w_pat  = val_w[PW-1:0];
    w_cnt  = cnt_sat[CW-1:0];
    w_len  = len_sat[LW-1:0];
    if (st == mpdm_pkg::ST_CLEAR) begin
      we.go   = 1'b1;
      we.fail = 1'b1;
      we.cnt  = 1'b1;
      w_node  = clr[GAW-1:8];
      w_ch    = clr[7:0];
      w_next  = '0;
      w_cnt   = '0;
    end else if (accept && node_w < 32'(NUM_STATES)) begin
      case (func)
        mpdm_pkg::FN_GOTO: we.go   = (val_w < 32'(NUM_STATES));
        mpdm_pkg::FN_FAIL: we.fail = (val_w < 32'(NUM_STATES));
        mpdm_pkg::FN_OENT: we.lst  = (slot_w < 32'(MAX_OUT)) && (val_w < 32'(MAX_PAT));
        mpdm_pkg::FN_OCNT: we.cnt  = 1'b1;
        default: ;
      endcase
    end
    // pattern length is addressed by pattern index, not state
    if (st != mpdm_pkg::ST_CLEAR && accept && func == mpdm_pkg::FN_PLEN
        && node_w < 32'(MAX_PAT)) begin
      we.len = 1'b1;
    end
  end

  // read addresses: data is registered and lands in the next cycle
  always_comb begin
    case (st)
      mpdm_pkg::ST_CNT: j_rd = '0;
      mpdm_pkg::ST_LEN: j_rd = j + CW'(1);
      default:          j_rd = j;
    endcase
    r_go   = {s, c};
    r_fail = s;
    r_cnt  = go_data;
    r_lst  = {s, j_rd[OW-1:0]};
    r_len  = (st == mpdm_pkg::ST_LST) ? lst_data : p;
  end

  mpdm_mem #(.SW(SW), .PW(PW), .OW(OW), .CW(CW), .LW(LW)) u_mem (
    .clk       (clk),
    .we        (we),
    .w_node    (w_node),
    .w_ch      (w_ch),
    .w_slot    (w_slot),
    .w_pidx    (w_pidx),
    .w_next    (w_next),
    .w_pat     (w_pat),
    .w_cnt     (w_cnt),
    .w_len     (w_len),
    .r_go      (r_go),
    .r_fail    (r_fail),
    .r_cnt     (r_cnt),
    .r_lst     (r_lst),
    .r_len     (r_len),
    .go_data   (go_data),
    .fail_data (fail_data),
    .cnt_data  (cnt_data),
    .lst_data  (lst_data),
    .len_data  (len_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= mpdm_pkg::ST_CLEAR;
      clr   <= '0;
      cur   <= '0;
      steps <= '0;
    end else begin
      st    <= st_next;
      clr   <= clr_next;
      cur   <= cur_next;
      steps <= steps_next;
    end
    s        <= s_next;
    c        <= c_next;
    n        <= n_next;
    j        <= j_next;
    p        <= p_next;
    pos_r    <= pos_next;
    strand_r <= strand_next;
  end

  // sequencer: clearing pass, goto lookup, failure walk, then one list/length pair per match
  always_comb begin
    st_next     = st;
    clr_next    = clr;
    cur_next    = cur;
    s_next      = s;
    c_next      = c;
    steps_next  = steps;
    n_next      = n;
    j_next      = j;
    p_next      = p;
    pos_next    = pos_r;
    strand_next = strand_r;
    case (st)
      mpdm_pkg::ST_CLEAR: begin
        clr_next = clr + GAW'(1);
        if (&clr) st_next = mpdm_pkg::ST_IDLE;
      end
      mpdm_pkg::ST_IDLE: begin
        if (accept && func == mpdm_pkg::FN_SCAN) begin
          s_next      = restart ? '0 : cur;
          c_next      = mpdm_pkg::map_char(ch, strand, ic);
          steps_next  = '0;
          pos_next    = position;
          strand_next = strand;
          st_next     = mpdm_pkg::ST_GO;
        end
      end
      mpdm_pkg::ST_GO: st_next = mpdm_pkg::ST_GCHK;
      mpdm_pkg::ST_GCHK: begin
        if (s != '0 && go_data == '0) begin
          if (32'(steps) >= 32'(NUM_STATES)) begin
            // walk ran too long: fall back to root
            s_next  = '0;
            st_next = mpdm_pkg::ST_GO;
          end else begin
            st_next = mpdm_pkg::ST_FCHK;
          end
        end else begin
          s_next   = go_data;
          cur_next = go_data;
          st_next  = mpdm_pkg::ST_CNT;
        end
      end
      mpdm_pkg::ST_FCHK: begin
        s_next     = fail_data;
        steps_next = steps + STW'(1);
        st_next    = mpdm_pkg::ST_GO;
      end
      mpdm_pkg::ST_CNT: begin
        n_next  = cnt_data;
        j_next  = '0;
        st_next = (cnt_data == '0) ? mpdm_pkg::ST_IDLE : mpdm_pkg::ST_LST;
      end
      mpdm_pkg::ST_LST: begin
        p_next  = lst_data;
        st_next = mpdm_pkg::ST_LEN;
      end
      mpdm_pkg::ST_LEN: begin
        if (emit) begin
          if (j + CW'(1) == n) begin
            st_next = mpdm_pkg::ST_IDLE;
          end else begin
            j_next  = j + CW'(1);
            st_next = mpdm_pkg::ST_LST;
          end
        end
      end
      default: st_next = mpdm_pkg::ST_IDLE;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      match_pattern  <= pidx_w[9:0];
      match_position <= strand_r ? pos_r : fwd_pos[POS_BITS-1:0];
      match_strand   <= strand_r;
      last           <= (j + CW'(1) == n);
    end
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_steps_bound, clk, rst, 32'(steps) <= 32'(NUM_STATES))
  `ASSERT_ALWAYS(a_cur_range, clk, rst, 32'(cur) < 32'(NUM_STATES))
  `ASSERT_IMPL(a_slot_range, clk, rst, st == mpdm_pkg::ST_LST || st == mpdm_pkg::ST_LEN, j < n)
  `ASSERT_NEXT(a_no_match_done, clk, rst, st == mpdm_pkg::ST_CNT && cnt_data == '0, st == mpdm_pkg::ST_IDLE)

endmodule
`default_nettype wire

// ===== tb/multi_pattern_dna_matcher_tb.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_dna_matcher_tb
// Loads small automata through write items, then scans character streams on
// both strands. A local scanner model predicts every match item, and each
// item out of the block is checked field by field against the oldest
// prediction. Sender gaps and receiver stalls are applied in phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module multi_pattern_dna_matcher_tb;

  localparam logic [2:0] FN_UNUSED6 = 3'd6;
  localparam logic [2:0] FN_UNUSED7 = 3'd7;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int SETTLE = 64;
  localparam logic [39:0] POS_MAX = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic [9:0]  pat;
    logic [39:0] pos;
    logic        strnd;
    logic        lst;
  } match_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] func = '0;
  logic [7:0] ch = '0;
  logic restart = 1'b0;
  logic strand = 1'b0;
  logic [39:0] position = '0;
  logic [9:0] node = '0;
  logic [3:0] slot = '0;
  logic [10:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [9:0] match_pattern;
  logic [39:0] match_position;
  logic match_strand;
  logic last;

  multi_pattern_dna_matcher u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .ch(ch),
    .restart(restart), .strand(strand), .position(position), .node(node),
    .slot(slot), .value(value), .out_valid(out_valid), .out_stall(out_stall),
    .match_pattern(match_pattern), .match_position(match_position),
    .match_strand(match_strand), .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // idling knobs, percent of cycles
  int gap_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int cycles = 0;

  // scanner model state
  logic [9:0]  goto_mem [0:262143];
  logic [9:0]  fail_mem [0:1023];
  logic [4:0]  cnt_mem  [0:1023];
  logic [9:0]  list_mem [0:16383];
  logic [10:0] len_mem  [0:1023];
  bit          list_set [0:16383];
  bit          len_set  [0:1023];
  logic [9:0]  scan_state;
  logic        case_fold;
  match_t      match_q[$];

  // complement on the reverse strand; anything but ACGT becomes N
  function automatic logic [7:0] complement(input logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    case (u)
      mpdm_pkg::CH_A: return mpdm_pkg::CH_T;
      mpdm_pkg::CH_T: return mpdm_pkg::CH_A;
      mpdm_pkg::CH_G: return mpdm_pkg::CH_C;
      mpdm_pkg::CH_C: return mpdm_pkg::CH_G;
      default: return mpdm_pkg::CH_N;
    endcase
  endfunction

  // apply one accepted item to the model, queue its matches
  task automatic predict_matches(input logic [2:0] f, input logic [7:0] c,
                                 input logic rs, input logic st,
                                 input logic [39:0] p, input logic [9:0] n,
                                 input logic [3:0] sl, input logic [10:0] v);
    logic [7:0] sym;
    logic [9:0] s;
    logic [9:0] pid;
    int steps;
    int cnt;
    match_t m;
    case (f)
      mpdm_pkg::FN_GOTO: if (v < mpdm_pkg::NUM_STATES) goto_mem[{n, c}] = v[9:0];
      mpdm_pkg::FN_FAIL: if (v < mpdm_pkg::NUM_STATES) fail_mem[n] = v[9:0];
      mpdm_pkg::FN_OENT: if (v < mpdm_pkg::MAX_PAT) begin
        list_mem[{n, sl}] = v[9:0];
        list_set[{n, sl}] = 1'b1;
      end
      mpdm_pkg::FN_OCNT:
        cnt_mem[n] = (v > mpdm_pkg::MAX_OUT) ? 5'(mpdm_pkg::MAX_OUT) : v[4:0];
      mpdm_pkg::FN_PLEN: begin
        len_mem[n] = (v > mpdm_pkg::MAX_LEN) ? 11'(mpdm_pkg::MAX_LEN) : v;
        len_set[n] = 1'b1;
      end
      mpdm_pkg::FN_SCAN: begin
        if (rs) scan_state = '0;
        sym = st ? complement(c) : c;
        if (case_fold && sym >= "A" && sym <= "Z") sym = sym + 8'd32;
        s = scan_state;
        steps = 0;
        // failure walk; a walk that never ends drops to the root
        while (s != 0 && goto_mem[{s, sym}] == 0) begin
          if (steps >= mpdm_pkg::NUM_STATES) begin
            s = '0;
            break;
          end
          s = fail_mem[s];
          steps++;
        end
        s = goto_mem[{s, sym}];
        scan_state = s;
        cnt = cnt_mem[s];
        for (int j = 0; j < cnt; j++) begin
          pid = list_mem[{s, 4'(j)}];
          m.pat = pid;
          m.pos = st ? p : p - 40'(len_mem[pid]) + 40'd1;
          m.strnd = st;
          m.lst = (j + 1 == cnt);
          match_q.push_back(m);
        end
      end
      default: ;
    endcase
  endtask

  // drive one item and wait for it to be taken
  task automatic send_item(input logic [2:0] f, input logic [7:0] c,
                           input logic rs, input logic st,
                           input logic [39:0] p, input logic [9:0] n,
                           input logic [3:0] sl, input logic [10:0] v);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    func = f; ch = c; restart = rs; strand = st;
    position = p; node = n; slot = sl; value = v;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_matches(f, c, rs, st, p, n, sl, v);
  endtask

  task automatic scan(input logic [7:0] c, input logic rs, input logic st,
                      input logic [39:0] p);
    send_item(mpdm_pkg::FN_SCAN, c, rs, st, p, '0, '0, '0);
  endtask

  task automatic load(input logic [2:0] f, input logic [9:0] n,
                      input logic [7:0] c, input logic [3:0] sl,
                      input logic [10:0] v);
    send_item(f, c, 1'b0, 1'b0, '0, n, sl, v);
  endtask

  // let the block drain before touching its register
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (match_q.size() != 0 || in_stall) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_case_fold(input logic v);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    case_fold = v;
  endtask

  // output lists and lengths for the states and patterns in use
  task automatic test_table_load();
    for (int p = 0; p < 32; p++) begin
      load(mpdm_pkg::FN_PLEN, 10'(p), '0, '0, 11'(p * 3 + 1));
    end
    load(mpdm_pkg::FN_PLEN, 10'd0, '0, '0, 11'd0);
    load(mpdm_pkg::FN_PLEN, 10'd1, '0, '0, 11'd1024);
    load(mpdm_pkg::FN_PLEN, 10'd2, '0, '0, 11'd2047);   // saturates
    load(mpdm_pkg::FN_PLEN, 10'd1023, '0, '0, 11'd5);
    for (int s = 0; s < 10; s++) begin
      for (int j = 0; j < mpdm_pkg::MAX_OUT; j++) begin
        load(mpdm_pkg::FN_OENT, (s == 9) ? 10'd1023 : 10'(s), '0, 4'(j),
             (s == 9 && j == 15) ? 11'd1023 : 11'($urandom_range(31)));
      end
    end
  endtask

  // trie for ACG, CG and a few corner states
  task automatic test_directed();
    load(mpdm_pkg::FN_GOTO, 10'd0, mpdm_pkg::CH_A, '0, 11'd1);
    load(mpdm_pkg::FN_GOTO, 10'd1, mpdm_pkg::CH_C, '0, 11'd2);
    load(mpdm_pkg::FN_GOTO, 10'd2, mpdm_pkg::CH_G, '0, 11'd3);
    load(mpdm_pkg::FN_GOTO, 10'd0, mpdm_pkg::CH_C, '0, 11'd4);
    load(mpdm_pkg::FN_GOTO, 10'd4, mpdm_pkg::CH_G, '0, 11'd5);
    load(mpdm_pkg::FN_FAIL, 10'd2, '0, '0, 11'd4);
    load(mpdm_pkg::FN_FAIL, 10'd3, '0, '0, 11'd5);
    load(mpdm_pkg::FN_OCNT, 10'd3, '0, '0, 11'd2);
    load(mpdm_pkg::FN_OCNT, 10'd5, '0, '0, 11'd31);      // count saturates
    load(mpdm_pkg::FN_OCNT, 10'd1023, '0, '0, 11'd16);
    load(mpdm_pkg::FN_GOTO, 10'd0, mpdm_pkg::CH_N, '0, 11'd1023);  // reverse of non-base
    // out of range writes, unused codes
    load(mpdm_pkg::FN_GOTO, 10'd0, mpdm_pkg::CH_T, '0, 11'd1024);
    load(mpdm_pkg::FN_OENT, 10'd3, '0, 4'd0, 11'd1024);
    send_item(FN_UNUSED6, 8'hFF, 1'b1, 1'b1, POS_MAX, 10'h3FF, 4'hF, 11'h7FF);
    send_item(FN_UNUSED7, 8'h00, 1'b0, 1'b0, '0, '0, '0, '0);
    scan(mpdm_pkg::CH_A, 1'b1, 1'b0, 40'd0);
    scan(mpdm_pkg::CH_C, 1'b0, 1'b0, 40'd1);
    scan(mpdm_pkg::CH_G, 1'b0, 1'b0, 40'd2);            // wraps at low position
    scan(mpdm_pkg::CH_G, 1'b0, 1'b1, POS_MAX);          // reverse G -> C
    scan(mpdm_pkg::CH_T, 1'b1, 1'b1, POS_MAX);          // reverse T -> A
    scan("x", 1'b0, 1'b1, 40'd77);            // becomes N on reverse
    scan("c", 1'b0, 1'b1, 40'd78);
    // failure links that loop between two states
    load(mpdm_pkg::FN_GOTO, 10'd0, "Z", '0, 11'd6);
    load(mpdm_pkg::FN_FAIL, 10'd6, '0, '0, 11'd7);
    load(mpdm_pkg::FN_FAIL, 10'd7, '0, '0, 11'd6);
    scan("Z", 1'b1, 1'b0, 40'd5);
    scan("Q", 1'b0, 1'b0, 40'd6);
  endtask

  // lowercase goto entries only match with folding on
  task automatic test_case_fold();
    load(mpdm_pkg::FN_GOTO, 10'd0, "g", '0, 11'd8);
    load(mpdm_pkg::FN_OCNT, 10'd8, '0, '0, 11'd1);
    scan(mpdm_pkg::CH_G, 1'b1, 1'b0, 40'd100);
    set_case_fold(1'b1);
    scan(mpdm_pkg::CH_G, 1'b1, 1'b0, 40'd101);
    scan(mpdm_pkg::CH_C, 1'b1, 1'b1, 40'd102);
    scan("g", 1'b1, 1'b0, 40'd103);
    set_case_fold(1'b0);
  endtask

  function automatic logic [7:0] rand_base();
    logic [7:0] b [8] = '{mpdm_pkg::CH_A, mpdm_pkg::CH_C, mpdm_pkg::CH_G,
                          mpdm_pkg::CH_T, "a", "c", "g", "t"};
    return ($urandom_range(19) == 0) ? 8'($urandom) : b[$urandom_range(7)];
  endfunction

  // random trie edits mixed into random scans
  task automatic test_random(input int items);
    int r;
    logic [9:0] n;
    logic [10:0] v;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      if (r < 70) begin
        scan(rand_base(), $urandom_range(15) == 0, 1'($urandom_range(1)),
             {8'($urandom), 32'($urandom)});
      end else if (r < 80) begin
        n = 10'($urandom_range(15));
        load(mpdm_pkg::FN_GOTO, n, rand_base(), '0, 11'($urandom_range(15) + 1));
      end else if (r < 85) begin
        n = 10'($urandom_range(15) + 1);
        load(mpdm_pkg::FN_FAIL, n, '0, '0, 11'($urandom_range(n - 1)));
      end else if (r < 91) begin
        load(mpdm_pkg::FN_OCNT, 10'($urandom_range(8)), '0, '0,
             11'($urandom_range(20)));
      end else if (r < 94) begin
        v = 11'($urandom);
        if (v < mpdm_pkg::MAX_PAT && !len_set[v[9:0]]) v = 11'($urandom_range(31));
        load(mpdm_pkg::FN_OENT, 10'($urandom_range(15)), '0, 4'($urandom), v);
      end else if (r < 96) begin
        load(mpdm_pkg::FN_PLEN, 10'($urandom), '0, '0, 11'($urandom));
      end else begin
        // noise: wide addresses, values always out of range
        send_item(3'($urandom_range(1) ? mpdm_pkg::FN_GOTO : mpdm_pkg::FN_FAIL),
                  8'($urandom), 1'($urandom), 1'($urandom),
                  {8'($urandom), 32'($urandom)},
                  10'($urandom), 4'($urandom), 11'($urandom) | 11'h400);
      end
    end
  endtask

  // match checker
  always @(posedge clk) begin
    match_t want;
    if (!rst && out_valid && !out_stall) begin
      if (match_q.size() == 0) begin
        errors++;
        $display("%0t: expected none, actual pat=%0d pos=%0h", $time,
                 match_pattern, match_position);
      end else begin
        want = match_q.pop_front();
        if (match_pattern !== want.pat || match_position !== want.pos ||
            match_strand !== want.strnd || last !== want.lst) begin
          errors++;
          $display("%0t: expected pat=%0d pos=%0h strand=%0b last=%0b", $time,
                   want.pat, want.pos, want.strnd, want.lst);
          $display("%0t: actual   pat=%0d pos=%0h strand=%0b last=%0b", $time,
                   match_pattern, match_position, match_strand, last);
        end
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("multi_pattern_dna_matcher_tb: errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 262144; i++) goto_mem[i] = '0;
    for (int i = 0; i < 1024; i++) begin
      fail_mem[i] = '0;
      cnt_mem[i] = '0;
      len_mem[i] = '0;
      len_set[i] = 1'b0;
    end
    for (int i = 0; i < 16384; i++) begin
      list_mem[i] = '0;
      list_set[i] = 1'b0;
    end
    scan_state = '0;
    case_fold = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    set_case_fold(1'b0);
    test_table_load();
    test_directed();
    test_case_fold();
    gap_pct = 0;  stall_pct = 0;  test_random(20);
    set_case_fold(1'b1);
    gap_pct = 47; stall_pct = 0;  test_random(20);
    set_case_fold(1'b0);
    gap_pct = 0;  stall_pct = 47; test_random(20);
    set_case_fold(1'b1);
    gap_pct = 21; stall_pct = 21; test_random(20);
    drain();
    if (errors == 0 && match_q.size() == 0) begin
      $display("multi_pattern_dna_matcher_tb: clean");
    end else begin
      $display("multi_pattern_dna_matcher_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
